@@ src/spq_pkg.sv @@
`default_nettype none

package spq_pkg;

  // store geometry
  localparam int DEPTH = 16;
  localparam int KEY_W = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OCC_W = 5;
  localparam int STS_W = 2;

  // operation codes
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  // result status codes
  localparam logic [STS_W-1:0] STS_DONE      = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL      = 2'd1;
  localparam logic [STS_W-1:0] STS_POP_EMPTY = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HOLD = 2'b10
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic execute;
  } dp_cmd_t;

endpackage

`default_nettype wire

@@ src/spq_ctrl.sv @@
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output dp_cmd_t      dp_cmd
);

  state_t state;
  state_t state_next;

  // a new transaction is taken whenever the result slot is free or being drained
  assign in_ready        = (state == ST_IDLE) || out_ready;
  assign out_valid       = (state == ST_HOLD);
  assign dp_cmd.execute  = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (dp_cmd.execute) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready && !dp_cmd.execute) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ src/spq_datapath.sv @@
`default_nettype none

module spq_datapath
  import spq_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire dp_cmd_t                 dp_cmd,
  input  wire logic                    command,
  input  wire logic signed [KEY_W-1:0] key,
  output logic signed [KEY_W-1:0]      popped_key,
  output logic [STS_W-1:0]             status,
  output logic [OCC_W-1:0]             occupancy
);

  logic signed [KEY_W-1:0] keys [DEPTH];
  logic signed [KEY_W-1:0] keys_next [DEPTH];
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [DEPTH-1:0]        le;
  logic                    is_full;
  logic                    is_empty;
  logic                    do_push;
  logic                    do_pop;
  logic [CNT_W+OCC_W-1:0]  occ_ext;

  assign is_full  = (count == CNT_W'(DEPTH));
  assign is_empty = (count == '0);
  assign do_push  = dp_cmd.execute && (cmd_t'(command) == CMD_PUSH) && !is_full;
  assign do_pop   = dp_cmd.execute && (cmd_t'(command) == CMD_POP) && !is_empty;

  // per-entry compare: occupied entry holds a key not above the new one
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (CNT_W'(i) < count) && (keys[i] <= key);
    end
  end

  // parallel shift: up by one past the insert point, down by one on pop
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      keys_next[i] = keys[i];
    end
    if (do_push) begin
      if (!le[0]) begin
        keys_next[0] = key;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (le[i]) begin
          keys_next[i] = keys[i];
        end else if (le[i-1]) begin
          keys_next[i] = key;
        end else begin
          keys_next[i] = keys[i-1];
        end
      end
    end else if (do_pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        keys_next[i] = keys[i+1];
      end
    end
  end

  // entry count
  always_comb begin
    count_next = count;
    if (do_push) count_next = count + CNT_W'(1);
    else if (do_pop) count_next = count - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push || do_pop) begin
      for (int i = 0; i < DEPTH; i++) keys[i] <= keys_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result register, loaded once per transaction
  assign occ_ext = {{OCC_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (dp_cmd.execute) begin
      occupancy  <= occ_ext[OCC_W-1:0];
      popped_key <= do_pop ? keys[0] : '0;
      priority if (cmd_t'(command) == CMD_PUSH && is_full) begin
        status <= STS_FULL;
      end else if (cmd_t'(command) == CMD_POP && is_empty) begin
        status <= STS_POP_EMPTY;
      end else begin
        status <= STS_DONE;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/sorted_array_priority_queue.sv @@
`default_nettype none

// Ascending priority queue of signed 32-bit keys, held sorted in DEPTH registers.
// A push (command 0) places its key after every stored key that is less than or
// equal to it, so equal keys leave in arrival order; a pop (command 1) returns the
// smallest key. Every transaction gives exactly one result, in the cycle after it is
// accepted: status 1 marks a push into a full queue, status 2 a pop of an empty
// queue, and occupancy is the count held afterwards. One transaction per cycle is
// sustained while the receiver drains each result: each entry compares itself to
// the new key and shifts in the same cycle, and the result register frees as it is
// drained. No clearing pass follows reset; the queue is empty at once.
module sorted_array_priority_queue
  import spq_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    command,
  input  wire logic signed [KEY_W-1:0] key,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [KEY_W-1:0]      popped_key,
  output logic [STS_W-1:0]             status,
  output logic [OCC_W-1:0]             occupancy
);

  dp_cmd_t dp_cmd;

  // handshake control
  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd)
  );

  // sorted store and result register
  spq_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .dp_cmd     (dp_cmd),
    .command    (command),
    .key        (key),
    .popped_key (popped_key),
    .status     (status),
    .occupancy  (occupancy)
  );

`ifndef SYNTHESIS
  // an empty result slot never blocks input
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("input stalled with no result held");

  // an accepted transaction shows its result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid) else $error("result missing after transaction");

  // a failed pop reports an empty queue and no key
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STS_POP_EMPTY) |-> (popped_key == '0 && occupancy == '0))
    else $error("pop on empty queue reported inconsistently");

  // a rejected push never reports a popped key
  a_full_nokey: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STS_FULL) |-> (popped_key == '0))
    else $error("rejected push carries a key");
`endif

endmodule

`default_nettype wire

@@ sim/sorted_array_priority_queue_tb.sv @@
`default_nettype none

module sorted_array_priority_queue_tb;
  import spq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_SLACK    = 4;

  // one expected result of the queue
  typedef struct {
    logic signed [KEY_W-1:0] popped_key;
    logic [STS_W-1:0]        status;
    logic [OCC_W-1:0]        occupancy;
  } queue_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    command = CMD_PUSH;
  logic signed [KEY_W-1:0] key = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [KEY_W-1:0] popped_key;
  logic [STS_W-1:0]        status;
  logic [OCC_W-1:0]        occupancy;

  // shadow copy of the sorted store
  logic signed [KEY_W-1:0] shadow_keys [DEPTH];
  int                      shadow_count = 0;
  queue_result_t           pending_results [$];
  queue_result_t           oldest_result;

  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  sorted_array_priority_queue u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .key        (key),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .popped_key (popped_key),
    .status     (status),
    .occupancy  (occupancy)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one accepted transaction to the shadow store and queue its result
  task automatic apply_queue_op(input cmd_t cmd, input logic signed [KEY_W-1:0] k);
    queue_result_t r;
    int pos;
    r.popped_key = '0;
    r.status     = STS_DONE;
    if (cmd == CMD_PUSH) begin
      if (shadow_count >= DEPTH) begin
        r.status = STS_FULL;
      end else begin
        // new key goes after every stored key less than or equal to it
        pos = 0;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_keys[i] <= k) pos = i + 1;
        end
        for (int i = shadow_count; i > pos; i--) begin
          shadow_keys[i] = shadow_keys[i-1];
        end
        shadow_keys[pos] = k;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = STS_POP_EMPTY;
      end else begin
        r.popped_key = shadow_keys[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_keys[i-1] = shadow_keys[i];
        end
        shadow_count--;
      end
    end
    r.occupancy = OCC_W'(shadow_count);
    pending_results.push_back(r);
  endtask

  // offer one transaction, called and returning at a falling edge
  task automatic send_transaction(input cmd_t cmd, input logic signed [KEY_W-1:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    key      <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_queue_op(cmd, k);
    @(negedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_for_results_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
    @(negedge clk);
  endtask

  // key mix: extremes, a narrow band for ties, and full-width noise
  function automatic logic signed [KEY_W-1:0] random_key();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0: begin
        case ($urandom_range(4))
          0:       random_key = 32'sh7FFF_FFFF;
          1:       random_key = 32'sh8000_0000;
          2:       random_key = 32'sh0000_0000;
          3:       random_key = -32'sd1;
          default: random_key = 32'sd1;
        endcase
      end
      1, 2, 3: random_key = KEY_W'($signed($urandom_range(16)) - 8);
      default: random_key = $urandom;
    endcase
  endfunction

  task automatic test_empty_pop();
    send_transaction(CMD_POP, 32'sh5A5A_A5A5);
  endtask

  task automatic test_fill_with_extremes();
    logic signed [KEY_W-1:0] fill_keys [DEPTH];
    fill_keys = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1, 32'sd5, 32'sd5,
                  -32'sd5, 32'sd5, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh4000_0000,
                  -32'sh4000_0000, 32'sh0000_FFFF, 32'sd2, 32'sd5};
    foreach (fill_keys[i]) send_transaction(CMD_PUSH, fill_keys[i]);
  endtask

  task automatic test_full_push();
    send_transaction(CMD_PUSH, 32'sd3);
  endtask

  task automatic test_pop_order();
    repeat (6) send_transaction(CMD_POP, $urandom);
  endtask

  // random traffic, push bias switched every 40 transactions to hit full and empty
  task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
    int push_pct;
    cmd_t cmd;
    send_idle_pct = s_pct;
    recv_idle_pct <= r_pct;
    push_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 85;
          1:       push_pct = 15;
          default: push_pct = 55;
        endcase
      end
      cmd = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
      send_transaction(cmd, random_key());
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    int saved_idle;
    saved_idle    = send_idle_pct;
    send_idle_pct = 0;
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 40; i++) begin
      send_transaction(($urandom_range(99) < 70) ? CMD_PUSH : CMD_POP, random_key());
    end
    send_idle_pct = saved_idle;
  endtask

  task automatic test_drain_pause();
    wait_for_results_drained();
    repeat (5) send_transaction(($urandom_range(1) != 0) ? CMD_PUSH : CMD_POP, random_key());
  endtask

  // receiver readiness, with a counted hold-off on request
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result popped_key=%0d status=%0d occupancy=%0d",
                 $time, popped_key, status, occupancy);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (popped_key !== oldest_result.popped_key) begin
          $display("%0t: popped_key expected %0d actual %0d",
                   $time, oldest_result.popped_key, popped_key);
          mismatch_count++;
        end
        if (status !== oldest_result.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, oldest_result.status, status);
          mismatch_count++;
        end
        if (occupancy !== oldest_result.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d",
                   $time, oldest_result.occupancy, occupancy);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, pending_results.size());
        $display("sorted_array_priority_queue_tb failed");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 19;
    recv_idle_pct <= 53;
    test_empty_pop();
    test_fill_with_extremes();
    test_full_push();
    test_pop_order();

    test_random_traffic(270, 19, 53);
    test_backpressure();
    test_drain_pause();
    test_random_traffic(270, 53, 19);
    test_drain_pause();
    test_random_traffic(260, 0, 0);

    wait_for_results_drained();
    if (mismatch_count == 0) begin
      $display("sorted_array_priority_queue_tb passed");
    end else begin
      $display("sorted_array_priority_queue_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
